// ----- hdl/lfm_pkg.sv -----
// Shared types and constants for the lamp fault monitor.
package lfm_pkg;

    localparam int unsigned VEC_W  = 20;
    localparam int unsigned NUM_W  = 5;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned IDX_W  = 2;

    localparam logic [OP_W-1:0] OP_SENSE_CHECK = 3'd0;
    localparam logic [OP_W-1:0] OP_TURN_ON     = 3'd1;
    localparam logic [OP_W-1:0] OP_TURN_OFF    = 3'd2;
    localparam logic [OP_W-1:0] OP_ACK_ONE     = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK_ALL     = 3'd4;
    localparam logic [OP_W-1:0] OP_BLINK_TICK  = 3'd5;

    localparam logic [IDX_W-1:0] REG_LAMPS_IN_USE = 2'd0;
    localparam logic [IDX_W-1:0] REG_ENABLE_MASK  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLINK_MASK   = 2'd2;

    localparam logic [NUM_W-1:0] LAMPS_IN_USE_RST = 5'd20;
    localparam logic [VEC_W-1:0] ENABLE_MASK_RST  = 20'hFFFFF;
    localparam logic [VEC_W-1:0] BLINK_MASK_RST   = 20'h00000;

    typedef struct packed {
        logic [NUM_W-1:0] lamps_in_use;
        logic [VEC_W-1:0] enable_mask;
        logic [VEC_W-1:0] blink_mask;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [NUM_W-1:0] lamp_number;
        logic             report_wanted;
        logic [VEC_W-1:0] sense_on;
    } t_item;

    typedef struct packed {
        logic [VEC_W-1:0] drive_vector;
        logic [VEC_W-1:0] fault_vector;
        logic [VEC_W-1:0] ack_vector;
        logic             alarm;
        logic             check_passed;
        logic [NUM_W-1:0] report_lamp;
    } t_result;

endpackage

// ----- hdl/lfm_cfg_regs.sv -----
// Configuration registers of the lamp fault monitor.
module lfm_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfm_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lfm_pkg::VEC_W-1:0]   i_cfg_data,
    output lfm_pkg::t_cfg               o_cfg
);

    lfm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lamps_in_use <= lfm_pkg::LAMPS_IN_USE_RST;
            r_cfg.enable_mask  <= lfm_pkg::ENABLE_MASK_RST;
            r_cfg.blink_mask   <= lfm_pkg::BLINK_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lfm_pkg::REG_LAMPS_IN_USE: begin
                    r_cfg.lamps_in_use <= i_cfg_data[lfm_pkg::NUM_W-1:0];
                end
                lfm_pkg::REG_ENABLE_MASK: begin
                    r_cfg.enable_mask <= i_cfg_data;
                end
                lfm_pkg::REG_BLINK_MASK: begin
                    r_cfg.blink_mask <= i_cfg_data;
                end
                default: begin
                    // Writes to an unassigned index are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/lfm_core.sv -----
// Lamp state registers and the per-transaction update logic.
module lfm_core #(
    parameter int unsigned LAMP_COUNT = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  lfm_pkg::t_item   i_item,
    input  lfm_pkg::t_cfg    i_cfg,
    output lfm_pkg::t_result o_result
);

    localparam int unsigned LC = LAMP_COUNT;

    logic [LC-1:0] r_commanded_on, n_commanded_on;
    logic [LC-1:0] r_fault_flags,  n_fault_flags;
    logic [LC-1:0] r_ack_flags,    n_ack_flags;
    logic [LC-1:0] r_drive_bits,   n_drive_bits;
    logic          r_blink_phase,  n_blink_phase;

    logic [31:0]   enable_wide, blink_wide, sense_wide;
    logic [31:0]   drive_out, fault_out, ack_out;
    logic [LC-1:0] use_mask, sel_bit, enable_v, blink_v, sense_v;
    logic [LC-1:0] blink_used, checked, match_v, bad, good, unack, lit;
    logic          passed;
    logic          took_effect;

    // Lamp masks are 20 bits wide at the ports; widen or trim to the lamp count.
    assign enable_wide = {12'b0, i_cfg.enable_mask};
    assign blink_wide  = {12'b0, i_cfg.blink_mask};
    assign sense_wide  = {12'b0, i_item.sense_on};
    assign enable_v    = enable_wide[LC-1:0];
    assign blink_v     = blink_wide[LC-1:0];
    assign sense_v     = sense_wide[LC-1:0];

    always_comb begin
        for (int k = 0; k < LC; k++) begin
            // A count beyond the lamp count saturates because k never reaches it.
            use_mask[k] = (6'(k) < {1'b0, i_cfg.lamps_in_use});
            sel_bit[k]  = ({1'b0, i_item.lamp_number} == 6'(k + 1)) && use_mask[k];
        end
    end

    assign blink_used = blink_v & use_mask;
    assign checked    = use_mask & (~blink_used | ~r_commanded_on | {LC{r_blink_phase}});
    assign match_v    = ~(r_commanded_on ^ sense_v);
    assign bad        = checked & ~match_v;
    assign good       = checked & match_v;
    assign unack      = good & r_fault_flags & r_commanded_on;
    assign lit        = r_blink_phase ? (r_commanded_on & blink_used) : '0;
    assign took_effect = |(sel_bit & enable_v);

    always_comb begin
        n_commanded_on = r_commanded_on;
        n_fault_flags  = r_fault_flags;
        n_ack_flags    = r_ack_flags;
        n_drive_bits   = r_drive_bits;
        n_blink_phase  = r_blink_phase;
        passed         = 1'b1;
        case (i_item.opcode)
            lfm_pkg::OP_SENSE_CHECK: begin
                n_ack_flags   = r_ack_flags & ~unack;
                n_fault_flags = (r_fault_flags & ~good) | bad;
                passed        = ~|bad;
            end
            lfm_pkg::OP_TURN_ON: begin
                if (took_effect) begin
                    n_drive_bits   = r_drive_bits | sel_bit;
                    n_commanded_on = r_commanded_on | sel_bit;
                end
            end
            lfm_pkg::OP_TURN_OFF: begin
                if (took_effect) begin
                    n_drive_bits   = r_drive_bits & ~sel_bit;
                    n_commanded_on = r_commanded_on & ~sel_bit;
                end
            end
            lfm_pkg::OP_ACK_ONE: begin
                n_ack_flags = r_ack_flags | (sel_bit & r_fault_flags);
            end
            lfm_pkg::OP_ACK_ALL: begin
                n_ack_flags = r_ack_flags | (r_fault_flags & use_mask);
            end
            lfm_pkg::OP_BLINK_TICK: begin
                n_drive_bits  = (r_drive_bits & ~blink_used) | lit;
                n_blink_phase = ~r_blink_phase;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commanded_on <= '0;
            r_fault_flags  <= '0;
            r_ack_flags    <= '0;
            r_drive_bits   <= '0;
            r_blink_phase  <= 1'b1;
        end else if (i_advance) begin
            r_commanded_on <= n_commanded_on;
            r_fault_flags  <= n_fault_flags;
            r_ack_flags    <= n_ack_flags;
            r_drive_bits   <= n_drive_bits;
            r_blink_phase  <= n_blink_phase;
        end
    end

    assign drive_out = 32'(n_drive_bits);
    assign fault_out = 32'(n_fault_flags);
    assign ack_out   = 32'(n_ack_flags);

    always_comb begin
        o_result.drive_vector = drive_out[lfm_pkg::VEC_W-1:0];
        o_result.fault_vector = fault_out[lfm_pkg::VEC_W-1:0];
        o_result.ack_vector   = ack_out[lfm_pkg::VEC_W-1:0];
        o_result.alarm        = |(n_fault_flags & ~n_ack_flags & use_mask);
        o_result.check_passed = passed;
        o_result.report_lamp  = '0;
        if ((i_item.opcode inside {lfm_pkg::OP_TURN_ON, lfm_pkg::OP_TURN_OFF})
            && took_effect && i_item.report_wanted) begin
            o_result.report_lamp = i_item.lamp_number;
        end
    end

endmodule

// ----- hdl/lamp_fault_monitor_top.sv -----
// Top level of the lamp fault monitor: input register, result register and handshakes.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_ready    opcode, lamp_number, report_wanted, sense_on
//  result    out        o_out_valid / i_out_ready  drive, fault, ack vectors, alarm,
//                                                  check_passed, report_lamp
//  config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// One transaction per cycle is sustained while results are taken; a result passes through the
// input register, then the state update into the result register.
// The lamp state registers change only when a transaction moves into the result register.
// A stalled result holds; the input register still takes a transaction while the
// result register is full and then waits behind it.
// Synchronous active-low reset clears the lamp state and loads the register defaults.
module lamp_fault_monitor_top #(
    parameter int unsigned LAMP_COUNT = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfm_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [lfm_pkg::VEC_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lfm_pkg::OP_W-1:0]    i_opcode,
    input  logic [lfm_pkg::NUM_W-1:0]   i_lamp_number,
    input  logic                        i_report_wanted,
    input  logic [lfm_pkg::VEC_W-1:0]   i_sense_on,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lfm_pkg::VEC_W-1:0]   o_drive_vector,
    output logic [lfm_pkg::VEC_W-1:0]   o_fault_vector,
    output logic [lfm_pkg::VEC_W-1:0]   o_ack_vector,
    output logic                        o_alarm,
    output logic                        o_check_passed,
    output logic [lfm_pkg::NUM_W-1:0]   o_report_lamp
);

    lfm_pkg::t_cfg    cfg;
    lfm_pkg::t_item   r_item;
    lfm_pkg::t_result r_result;
    lfm_pkg::t_result core_result;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.opcode        <= i_opcode;
            r_item.lamp_number   <= i_lamp_number;
            r_item.report_wanted <= i_report_wanted;
            r_item.sense_on      <= i_sense_on;
        end
        if (advance) begin
            r_result <= core_result;
        end
    end

    lfm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lfm_core #(
        .LAMP_COUNT (LAMP_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    assign o_out_valid    = r_out_valid;
    assign o_drive_vector = r_result.drive_vector;
    assign o_fault_vector = r_result.fault_vector;
    assign o_ack_vector   = r_result.ack_vector;
    assign o_alarm        = r_result.alarm;
    assign o_check_passed = r_result.check_passed;
    assign o_report_lamp  = r_result.report_lamp;

endmodule
